// ===== hw/rtl/kway_merge_dedup_top_defines.svh =====
// Assertion helpers for the RTL.
`ifndef KWAY_MERGE_DEDUP_TOP_DEFINES_SVH
`define KWAY_MERGE_DEDUP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KMD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kmd_pkg.sv =====
package kmd_pkg;

   // fixed field widths
   localparam int LANE_W     = 3;
   localparam int HALF_W     = 60;
   localparam int ACT_W      = 4;
   localparam int LETTER_W   = 5;
   localparam int HALF_CHARS = 12;
   localparam int DATA_W     = 128;

   // defaults for top level parameters
   localparam int LANES_DEF      = 8;
   localparam int WORD_CHARS_DEF = 24;

   localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic              any;      // some head seen so far
      logic              ready;    // no active lane is waiting for a word
      logic              all_fin;  // every active lane has ended
      logic [1:0]        n_valid;  // heads seen, saturates at two
      logic [HALF_W-1:0] best_high;
      logic [HALF_W-1:0] best_low;
   } kmd_cand_type;

   // head write broadcast to all cells
   typedef struct packed {
      logic              en;
      logic              lane_end;
      logic [LANE_W-1:0] lane;
      logic [HALF_W-1:0] high;
      logic [HALF_W-1:0] low;
   } kmd_wr_type;

   // mask keeping the top n_chars letters of a half word
   function automatic logic [HALF_W-1:0] half_mask(input int n_chars);
      logic [HALF_W-1:0] m;
      int                bits;
      bits = n_chars * LETTER_W;
      for (int b = 0; b < HALF_W; b++) begin
         m[b] = (b >= HALF_W - bits);
      end
      return m;
   endfunction

endpackage

// ===== hw/rtl/kmd_cell.sv =====
module kmd_cell import kmd_pkg::*; #(
   parameter int LANES = LANES_DEF,
   parameter int IDX   = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ACT_W-1:0]           n_active,
   input  kmd_wr_type                 wr,
   input  logic                       pop_en,
   input  logic [$clog2(LANES)-1:0]   pop_lane,
   input  kmd_cand_type               cand_in,
   input  logic [$clog2(LANES)-1:0]   lane_in,
   output kmd_cand_type               cand_out,
   output logic [$clog2(LANES)-1:0]   lane_out,
   output logic                       head_valid
);

   localparam int LW = $clog2(LANES);

   logic              valid_ff, valid_in;
   logic              fin_ff, fin_in;
   logic [HALF_W-1:0] high_ff, high_in;
   logic [HALF_W-1:0] low_ff, low_in;
   kmd_cand_type      cand_ff, cand_fold_in;
   logic [LW-1:0]     lane_ff, lane_fold_in;
   logic              active;
   logic              hit_wr;
   logic              less;

   assign active = int'(n_active) > IDX;
   assign hit_wr = wr.en && active && (int'(wr.lane) == IDX);
   assign less   = {high_ff, low_ff} < {cand_in.best_high, cand_in.best_low};

   // head word and lane state
   always_comb begin
      valid_in = valid_ff;
      fin_in   = fin_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      if (hit_wr) begin
         if (wr.lane_end) begin
            fin_in = 1'b1;
         end else if (!fin_ff && !valid_ff) begin
            valid_in = 1'b1;
            high_in  = wr.high;
            low_in   = wr.low;
         end
      end
      if (pop_en && (int'(pop_lane) == IDX)) begin
         valid_in = 1'b0;
      end
   end

   // fold this lane into the candidate coming from the left
   always_comb begin
      cand_fold_in = cand_in;
      lane_fold_in = lane_in;
      if (active) begin
         if (valid_ff) begin
            if (!cand_in.any || less) begin
               cand_fold_in.best_high = high_ff;
               cand_fold_in.best_low  = low_ff;
               lane_fold_in           = LW'(IDX);
            end
            cand_fold_in.any = 1'b1;
            if (cand_in.n_valid != 2'd2) begin
               cand_fold_in.n_valid = cand_in.n_valid + 2'd1;
            end
         end else if (!fin_ff) begin
            cand_fold_in.ready = 1'b0;
         end
         if (!fin_ff) begin
            cand_fold_in.all_fin = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         fin_ff   <= fin_in;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
      cand_ff <= cand_fold_in;
      lane_ff <= lane_fold_in;
   end

   assign cand_out   = cand_ff;
   assign lane_out   = lane_ff;
   assign head_valid = valid_ff;

endmodule

// ===== hw/rtl/kway_merge_dedup_top.sv =====
// Channel | Dir | Handshake          | Payload
// req     | in  | req_tvalid/tready  | tdata: lane, word_high, word_low; tlast: lane_end
// rsp     | out | rsp_tvalid/tready  | tdata: source_lane, out_high, out_low;
//         |     |                    | tuser: duplicate; tlast: all_done
// csr     | in  | csr_valid/ready    | csr_data: active_lanes
//
// One item takes a head write step, a scan while the running minimum walks the row
// of lane cells, and an emit step.
// Reset is synchronous; it clears head valid and lane ended flags and sets
// active_lanes to 8. No clearing pass is needed.
// A result waiting on rsp does not stop the next request transaction; that
// item's emit cycle waits until the output register is free.
`include "kway_merge_dedup_top_defines.svh"

module kway_merge_dedup_top import kmd_pkg::*; #(
   parameter int LANES      = LANES_DEF,
   parameter int WORD_CHARS = WORD_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // lane[2:0], word_high[62:3], word_low[122:63], 0
   input  logic              req_tlast,   // lane_end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // source_lane[2:0], out_high[62:3],
                                          // out_low[122:63], 0
   output logic              rsp_tuser,   // duplicate
   output logic              rsp_tlast,   // all_done
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ACT_W-1:0]  csr_data     // active_lanes
);

   localparam int LW    = $clog2(LANES);
   localparam int CNT_W = $clog2(LANES);
   localparam int HC    = (WORD_CHARS < HALF_CHARS) ? WORD_CHARS : HALF_CHARS;
   localparam int LC    = (WORD_CHARS > HALF_CHARS) ? WORD_CHARS - HALF_CHARS : 0;
   localparam logic [HALF_W-1:0] HI_MASK = half_mask(HC);
   localparam logic [HALF_W-1:0] LO_MASK = half_mask(LC);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ACT_W-1:0]  active_ff, active_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_dup_ff, rsp_dup_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              have_last_ff, have_last_in;
   logic [HALF_W-1:0] last_high_ff, last_high_in;
   logic [HALF_W-1:0] last_low_ff, last_low_in;

   logic [ACT_W-1:0]  n_eff;
   logic [LANE_W-1:0] req_lane;
   logic              req_acc;
   logic              lane_ok;
   kmd_wr_type        wr;
   kmd_cand_type      cand_chain [LANES+1];
   logic [LW-1:0]     lane_chain [LANES+1];
   logic [LANES-1:0]  valid_vec;
   kmd_cand_type      fin;
   logic [LW-1:0]     fin_lane;
   logic              do_pop, do_done, emit, out_free, load, pop_en, dup, done;

   // clamp the active lane count into 1..LANES
   always_comb begin
      if (active_ff == '0) begin
         n_eff = ACT_W'(1);
      end else if (int'(active_ff) > LANES) begin
         n_eff = ACT_W'(LANES);
      end else begin
         n_eff = active_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_lane   = req_tdata[LANE_W-1:0];
   assign lane_ok    = {1'b0, req_lane} < n_eff;

   // head write broadcast, letters past WORD_CHARS forced to zero
   always_comb begin
      wr.en       = req_acc && lane_ok;
      wr.lane_end = req_tlast;
      wr.lane     = req_lane;
      wr.high     = req_tdata[LANE_W +: HALF_W] & HI_MASK;
      wr.low      = req_tdata[LANE_W+HALF_W +: HALF_W] & LO_MASK;
   end

   // empty candidate enters the row at lane 0
   always_comb begin
      cand_chain[0]           = '0;
      cand_chain[0].ready     = 1'b1;
      cand_chain[0].all_fin   = 1'b1;
      lane_chain[0]           = '0;
   end

   // row of lane cells
   for (genvar g = 0; g < LANES; g++) begin : g_cell
      kmd_cell #(
         .LANES (LANES),
         .IDX   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .n_active   (n_eff),
         .wr         (wr),
         .pop_en     (pop_en),
         .pop_lane   (fin_lane),
         .cand_in    (cand_chain[g]),
         .lane_in    (lane_chain[g]),
         .cand_out   (cand_chain[g+1]),
         .lane_out   (lane_chain[g+1]),
         .head_valid (valid_vec[g])
      );
   end

   // pop decision from the end of the row
   assign fin      = cand_chain[LANES];
   assign fin_lane = lane_chain[LANES];
   assign do_pop   = fin.ready && fin.any;
   assign do_done  = fin.all_fin && !fin.any;
   assign emit     = do_pop || do_done;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = (state_ff == ST_EMIT) && emit && out_free;
   assign pop_en   = load && do_pop;
   assign dup      = do_pop && have_last_ff &&
                     ({fin.best_high, fin.best_low} == {last_high_ff, last_low_ff});
   assign done     = fin.all_fin && (do_pop ? (fin.n_valid == 2'd1) : 1'b1);

   // sequencer, output register and last popped word
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      active_in    = csr_valid ? csr_data : active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_done_in  = rsp_done_ff;
      have_last_in = have_last_ff;
      last_high_in = last_high_ff;
      last_low_in  = last_low_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(LANES - 1)) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!emit || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (do_pop) begin
            rsp_data_in[LANE_W-1:0]              = LANE_W'(fin_lane);
            rsp_data_in[LANE_W +: HALF_W]        = fin.best_high;
            rsp_data_in[LANE_W+HALF_W +: HALF_W] = fin.best_low;
         end
         rsp_dup_in  = dup;
         rsp_done_in = done;
      end
      if (pop_en) begin
         have_last_in = 1'b1;
         last_high_in = fin.best_high;
         last_low_in  = fin.best_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         active_ff    <= ACT_RESET;
         rsp_valid_ff <= 1'b0;
         have_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         have_last_ff <= have_last_in;
      end
      rsp_data_ff  <= rsp_data_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_done_ff  <= rsp_done_in;
      last_high_ff <= last_high_in;
      last_low_ff  <= last_low_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_dup_ff;
   assign rsp_tlast  = rsp_done_ff;

   // checks
   `KMD_ASSERT_NOW(a_pop_hits_head, pop_en, valid_vec[fin_lane], "pop of an empty head")
   `KMD_ASSERT_NEXT(a_pop_clears_head, pop_en, !valid_vec[$past(fin_lane)],
      "popped head still valid")
   `KMD_ASSERT_NEXT(a_pop_sets_last, pop_en,
      have_last_ff && (last_high_ff == $past(fin.best_high)) &&
      (last_low_ff == $past(fin.best_low)), "last word not updated on pop")

endmodule

// ===== sim/tb_kway_merge_dedup_top.sv =====
`timescale 1ns / 1ps

module tb_kway_merge_dedup_top import kmd_pkg::*; ();

   localparam int NUM_LANES = LANES_DEF;
   localparam int ITEM_CYCLES = NUM_LANES + 2;

   // one popped word as it leaves the block
   typedef struct packed {
      logic [LANE_W-1:0] lane;
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
      logic              dup;
      logic              done;
   } merge_out_type;

   // lane heads, end flags and last popped word, plus the pops still owed
   class merge_scoreboard_type;
      logic [HALF_W-1:0] head_hi [NUM_LANES];
      logic [HALF_W-1:0] head_lo [NUM_LANES];
      bit                head_full [NUM_LANES];
      bit                lane_ended [NUM_LANES];
      logic [HALF_W-1:0] prev_hi;
      logic [HALF_W-1:0] prev_lo;
      bit                prev_seen;
      logic [ACT_W-1:0]  act_lanes;
      merge_out_type     expected_pops [$];
      int                errors;
      int                n_results;
      int                n_dups;
      int                n_done;

      function new();
         for (int i = 0; i < NUM_LANES; i++) begin
            head_hi[i] = '0;
            head_lo[i] = '0;
            head_full[i] = 1'b0;
            lane_ended[i] = 1'b0;
         end
         prev_hi = '0;
         prev_lo = '0;
         prev_seen = 1'b0;
         act_lanes = ACT_RESET;
         errors = 0;
         n_results = 0;
         n_dups = 0;
         n_done = 0;
      endfunction

      // 0 acts as one lane, anything above the lane count as all lanes
      function int lanes_in_use();
         if (act_lanes == 0) return 1;
         if (act_lanes > NUM_LANES) return NUM_LANES;
         return int'(act_lanes);
      endfunction

      function bit merge_finished();
         for (int i = 0; i < lanes_in_use(); i++) begin
            if (!lane_ended[i] || head_full[i]) return 1'b0;
         end
         return 1'b1;
      endfunction

      // apply one accepted request and queue the pop it causes, if any
      function void predict_step(logic [LANE_W-1:0] lane, logic [HALF_W-1:0] hi,
                                 logic [HALF_W-1:0] lo, logic fin);
         int            n;
         int            best;
         bit            ready;
         bit            any;
         merge_out_type r;
         n = lanes_in_use();
         best = 0;
         ready = 1'b1;
         any = 1'b0;
         r = '0;
         // all 24 letters are kept at the default word length, so no masking
         if (lane < n) begin
            if (fin) begin
               lane_ended[lane] = 1'b1;
            end else if (!lane_ended[lane] && !head_full[lane]) begin
               head_hi[lane] = hi;
               head_lo[lane] = lo;
               head_full[lane] = 1'b1;
            end
         end
         // smallest head wins, lowest lane on a tie
         for (int i = 0; i < n; i++) begin
            if (head_full[i]) begin
               if (!any || {head_hi[i], head_lo[i]} < {head_hi[best], head_lo[best]})
                  best = i;
               any = 1'b1;
            end else if (!lane_ended[i]) begin
               ready = 1'b0;
            end
         end
         if (ready && any) begin
            r.lane = LANE_W'(best);
            r.hi = head_hi[best];
            r.lo = head_lo[best];
            r.dup = prev_seen && ({r.hi, r.lo} == {prev_hi, prev_lo});
            head_full[best] = 1'b0;
            prev_hi = r.hi;
            prev_lo = r.lo;
            prev_seen = 1'b1;
            r.done = merge_finished();
            expected_pops.push_back(r);
         end else if (merge_finished()) begin
            r.done = 1'b1;
            expected_pops.push_back(r);
         end
      endfunction

      function void field_check(string what, logic [HALF_W-1:0] want,
                                logic [HALF_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      function void check_result(merge_out_type got);
         merge_out_type want;
         if (expected_pops.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual lane %0d %h_%h dup %b done %b",
                     $time, got.lane, got.hi, got.lo, got.dup, got.done);
            return;
         end
         want = expected_pops.pop_front();
         n_results++;
         if (want.dup) n_dups++;
         if (want.done) n_done++;
         field_check("source_lane", HALF_W'(want.lane), HALF_W'(got.lane));
         field_check("out_high", want.hi, got.hi);
         field_check("out_low", want.lo, got.lo);
         field_check("duplicate", HALF_W'(want.dup), HALF_W'(got.dup));
         field_check("all_done", HALF_W'(want.done), HALF_W'(got.done));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              req_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_valid;
   logic              csr_ready;
   logic [ACT_W-1:0]  csr_data;

   merge_scoreboard_type sb = new();

   // stimulus state
   int unsigned kcur [NUM_LANES];
   int unsigned kglob;
   int          n_items;
   bit          no_gaps;
   bit          hold_rsp;

   kway_merge_dedup_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [HALF_W-1:0] rand60();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[HALF_W-1:0];
   endfunction

   // word strictly increasing in k: four base-26 letters, then a fixed tail
   // of up to 20 letters (codes 1..31) derived from k
   function automatic logic [2*HALF_W-1:0] word_of(int unsigned k);
      logic [2*HALF_W-1:0] w;
      int unsigned         q;
      int unsigned         h;
      int                  tail;
      w = '0;
      q = k;
      for (int p = 3; p >= 0; p--) begin
         w[2*HALF_W-1-LETTER_W*p -: LETTER_W] = LETTER_W'(q % 26 + 1);
         q = q / 26;
      end
      h = k * 32'd2654435761;
      tail = h % 21;
      for (int p = 4; p < 4 + tail; p++) begin
         h = h * 32'd1103515245 + 32'd12345;
         w[2*HALF_W-1-LETTER_W*p -: LETTER_W] = LETTER_W'((h >> 16) % 31 + 1);
      end
      return w;
   endfunction

   // one request transaction, with an optional idle gap in front
   task automatic send_item(input logic [LANE_W-1:0] lane, input logic [HALF_W-1:0] hi,
                            input logic [HALF_W-1:0] lo, input logic fin);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, lo, hi, lane};
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      sb.predict_step(lane, hi, lo, fin);
      n_items++;
   endtask

   // mostly sorted refills of lanes that wait for a word; the rest is
   // traffic the block must ignore, and end marks once the merge winds down
   task automatic make_item(input bit ending, output logic [LANE_W-1:0] lane,
                            output logic [HALF_W-1:0] hi, output logic [HALF_W-1:0] lo,
                            output logic fin);
      int                  n;
      int                  needy [$];
      int                  blocked [$];
      int unsigned         k;
      logic [2*HALF_W-1:0] w;
      n = sb.lanes_in_use();
      for (int i = 0; i < NUM_LANES; i++) begin
         if (i < n && !sb.lane_ended[i] && !sb.head_full[i]) needy.push_back(i);
         else blocked.push_back(i);
      end
      lane = '0;
      hi = rand60();
      lo = rand60();
      fin = 1'b0;
      if (needy.size() > 0 && ($urandom_range(0, 99) < 85 || blocked.size() == 0)) begin
         lane = LANE_W'(needy[$urandom_range(0, needy.size() - 1)]);
         if (ending && $urandom_range(0, 3) == 0) begin
            fin = 1'b1;
         end else begin
            kglob += $urandom_range(0, 1);
            k = kglob + $urandom_range(0, 3);
            if (k < kcur[lane]) k = kcur[lane];
            kcur[lane] = k;
            w = word_of(k);
            hi = w[2*HALF_W-1:HALF_W];
            lo = w[HALF_W-1:0];
         end
      end else if (ending && $urandom_range(0, 1) == 1) begin
         // end mark anywhere: held head, repeated end or inactive lane
         lane = LANE_W'($urandom_range(0, NUM_LANES - 1));
         fin = 1'b1;
      end else begin
         lane = LANE_W'(blocked[$urandom_range(0, blocked.size() - 1)]);
         fin = (lane >= n) && ($urandom_range(0, 1) == 1);
      end
   endtask

   task automatic run_items(input int count, input bit ending);
      logic [LANE_W-1:0] lane;
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
      logic              fin;
      for (int i = 0; i < count; i++) begin
         make_item(ending, lane, hi, lo, fin);
         send_item(lane, hi, lo, fin);
      end
   endtask

   // drop valid, wait for every owed pop, then cover an item still in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_pops.size() != 0) @(posedge clock);
      repeat (2 * ITEM_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [ACT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.act_lanes = value;
   endtask

   // result side: check each transaction, stall at random or on request
   initial begin
      int            stall_left;
      merge_out_type got;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.lane = rsp_tdata[LANE_W-1:0];
            got.hi = rsp_tdata[LANE_W+HALF_W-1:LANE_W];
            got.lo = rsp_tdata[LANE_W+2*HALF_W-1:LANE_W+HALF_W];
            got.dup = rsp_tuser;
            got.done = rsp_tlast;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall_left = 399;
            rsp_tready <= 1'b0;
         end else if (no_gaps || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   // main sequence
   initial begin
      logic [LANE_W-1:0]   lane;
      logic [HALF_W-1:0]   hi;
      logic [HALF_W-1:0]   lo;
      logic                fin;
      logic [2*HALF_W-1:0] w;
      int                  extra;
      int                  guard;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      n_items = 0;
      no_gaps = 1'b0;
      hold_rsp = 1'b0;
      extra = 0;
      guard = 0;
      kglob = $urandom_range(0, 440000);
      for (int i = 0; i < NUM_LANES; i++) kcur[i] = kglob;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, all eight lanes active from reset
      send_item(LANE_W'(NUM_LANES - 1), '1, '1, 1'b0);   // largest word, parks in top lane
      send_item(LANE_W'(0), '0, '0, 1'b0);               // empty word
      send_item(LANE_W'(0), rand60(), rand60(), 1'b0);   // lane occupied, ignored
      w = word_of(kglob);
      for (int i = 1; i < NUM_LANES - 1; i++)
         send_item(LANE_W'(i), w[2*HALF_W-1:HALF_W], w[HALF_W-1:0], 1'b0);
      send_item(LANE_W'(0), '0, '0, 1'b0);               // repeat of the empty word
      // tie, low lane wins
      send_item(LANE_W'(0), w[2*HALF_W-1:HALF_W], w[HALF_W-1:0], 1'b0);
      send_item(LANE_W'(0), w[2*HALF_W-1:HALF_W], w[HALF_W-1:0], 1'b0);
      kglob++;
      kcur[0] = kglob;
      w = word_of(kglob);
      send_item(LANE_W'(0), w[2*HALF_W-1:HALF_W], w[HALF_W-1:0], 1'b0);

      // random phases over several lane counts
      wait_idle();
      write_active(4'd0);
      run_items(110, 1'b0);
      wait_idle();
      write_active(4'd3);
      run_items(170, 1'b0);
      wait_idle();
      write_active(4'd15);
      run_items(120, 1'b0);
      hold_rsp = 1'b1;                            // long output stall, input keeps coming
      run_items(180, 1'b0);
      wait_idle();
      write_active(4'd5);
      run_items(140, 1'b0);
      wait_idle();
      write_active(4'd8);
      run_items(140, 1'b0);

      // wind down: single lane first, then every lane
      wait_idle();
      write_active(4'd1);
      run_items(40, 1'b1);
      wait_idle();
      write_active(4'd8);
      while (extra < 12 && guard < 600) begin
         make_item(1'b1, lane, hi, lo, fin);
         send_item(lane, hi, lo, fin);
         if (sb.merge_finished()) extra++;
         guard++;
      end
      wait_idle();

      $display("Sent %0d requests across active-lane settings 0, 3, 15, 5, 8, 1 and 8,",
               n_items);
      $display("checked %0d pops, %0d flagged as repeats, %0d with the merge-complete flag.",
               sb.n_results, sb.n_dups, sb.n_done);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_cell.sv
hw/rtl/kway_merge_dedup_top.sv
sim/tb_kway_merge_dedup_top.sv
